>>> rtl/lkv_pkg.sv
// shared types and constants for the lru key-value cache
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // request opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // capacity register after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // value returned by a get that misses
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } lkv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_get;
  } lkv_stat_t;

endpackage

>>> rtl/lkv_ctrl.sv
// request sequencing and result handshake for the lru key-value cache
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lkv_pkg::lkv_stat_t stat,
  output lkv_pkg::lkv_cmd_t  cmd
);
  import lkv_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic commit;

  // a request is taken only between updates
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // a get waits while the previous result is still unclaimed
  assign commit = (state_r == S_EXEC) &&
                  !(stat.is_get && out_valid_r && !out_ready);

  assign cmd.capture = accept;
  assign cmd.commit  = commit;
  assign out_valid   = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit && stat.is_get) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a get never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit && stat.is_get && out_valid_r |-> out_ready)
    else $error("get result overwrote an unclaimed result");

  // every accepted request is committed before the next one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request accepted while another is in flight");

endmodule

>>> rtl/lkv_datapath.sv
// slot store, key compare and recency shift for the lru key-value cache
module lkv_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lkv_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                             in_opcode,
  input  logic [lkv_pkg::KEY_W-1:0]        in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_value,
  input  lkv_pkg::lkv_cmd_t                cmd,
  output lkv_pkg::lkv_stat_t               stat,
  output logic                             out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value
);
  import lkv_pkg::*;

  // slots in recency order, slot 0 most recent, valid slots form a prefix
  logic [MAX_ENTRIES-1:0] slot_valid_r, slot_valid_nxt;
  logic [KEY_W-1:0]       slot_key_r   [MAX_ENTRIES];
  logic [KEY_W-1:0]       slot_key_nxt [MAX_ENTRIES];
  logic [VAL_W-1:0]       slot_val_r   [MAX_ENTRIES];
  logic [VAL_W-1:0]       slot_val_nxt [MAX_ENTRIES];

  logic [CFG_W-1:0] capacity_r;
  logic [CFG_W-1:0] cap_lim;
  logic [CFG_W-1:0] new_cap_lim;

  // captured request and compare results
  logic                   req_op_r;
  logic [KEY_W-1:0]       req_key_r;
  logic [VAL_W-1:0]       req_val_r;
  logic                   hit_r;
  logic [VAL_W-1:0]       hit_val_r;
  logic [MAX_ENTRIES-1:0] mask_r;

  logic [MAX_ENTRIES-1:0] eq_vec;
  logic                   hit_c;
  logic [VAL_W-1:0]       hit_val_c;
  logic [MAX_ENTRIES-1:0] mask_c;
  logic [VAL_W-1:0]       front_val;

  logic                   out_hit_r;
  logic [VAL_W-1:0]       out_val_r;

  // capacity zero acts as one, values above the slot count saturate naturally
  assign cap_lim     = (capacity_r == '0) ? CFG_W'(1) : capacity_r;
  assign new_cap_lim = (cfg_wr_data == '0) ? CFG_W'(1) : cfg_wr_data;

  // parallel key compare against valid slots
  always_comb begin
    hit_val_c = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      eq_vec[i] = slot_valid_r[i] && (slot_key_r[i] == in_key);
      hit_val_c = hit_val_c | (eq_vec[i] ? slot_val_r[i] : '0);
    end
    hit_c = |eq_vec;
  end

  // shift mask: slots 0..pos take part in the move to front
  always_comb begin
    mask_c = '0;
    if (hit_c) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        mask_c[i] = |(eq_vec & ({MAX_ENTRIES{1'b1}} << i));
      end
    end else if (in_opcode == OP_SET) begin
      // shift through the first free slot, or the last slot in use when full; the new entry lands in slot 0
      mask_c[0] = 1'b1;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        mask_c[i] = slot_valid_r[i-1] && (i < int'(cap_lim));
      end
    end
  end

  // request and compare stage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op_r  <= in_opcode;
      req_key_r <= in_key;
      req_val_r <= in_value;
      hit_r     <= hit_c;
      hit_val_r <= hit_val_c;
      mask_r    <= mask_c;
    end
  end

  assign stat.is_get = (req_op_r == OP_GET);

  // entry that lands in slot 0
  assign front_val = (stat.is_get && hit_r) ? hit_val_r : req_val_r;

  // recency shift on commit, trim on capacity write
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_key_nxt[i] = slot_key_r[i];
      slot_val_nxt[i] = slot_val_r[i];
    end
    if (cmd.commit && mask_r[0]) begin
      slot_valid_nxt[0] = 1'b1;
      slot_key_nxt[0]   = req_key_r;
      slot_val_nxt[0]   = front_val;
    end
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      if (cmd.commit && mask_r[i]) begin
        slot_valid_nxt[i] = slot_valid_r[i-1];
        slot_key_nxt[i]   = slot_key_r[i-1];
        slot_val_nxt[i]   = slot_val_r[i-1];
      end
    end
    if (cfg_wr_en) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (i >= int'(new_cap_lim)) slot_valid_nxt[i] = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      capacity_r   <= CAP_RESET;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_key_r[i] <= slot_key_nxt[i];
      slot_val_r[i] <= slot_val_nxt[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit && stat.is_get) begin
      out_hit_r <= hit_r;
      out_val_r <= hit_r ? hit_val_r : MISS_VALUE;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

  // keys are unique among valid slots
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("key matched in more than one slot");

  // valid slots stay a prefix
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((slot_valid_r >> 1) & ~slot_valid_r) == '0)
    else $error("valid slots are not a prefix");

  // never more entries than the capacity allows
  a_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) <= int'(cap_lim))
    else $error("entry count exceeds capacity");

  // a committed move or insert leaves slot 0 valid
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && mask_r[0] |=> slot_valid_r[0])
    else $error("slot 0 not valid after update");

endmodule

>>> rtl/lru_key_value_cache.sv
// top level of the fully associative lru key-value cache
//
// Requests arrive on the in_ channel (valid/ready): in_opcode selects get or
// set, in_key is compared for equality, in_value is stored by set.
// Each get yields one result on the out_ channel (valid/ready): out_hit and
// out_read_value, which is the stored value on a hit and -1 on a miss.
// A set yields no result.
// Capacity is written through cfg_wr_en/cfg_wr_data only while the cache is
// idle, a rule for the user that the block does not enforce; zero acts as one,
// lowering it drops the least recent entries at once. A request's key is
// compared against every slot in parallel and the match registered, then the
// recency order is shifted. A get's result is registered when its shift
// commits. Only one request is in flight, so a new request is taken only
// after the previous one has committed.
// If the receiver stalls, the result is held in the output register and the
// next request is still accepted; a get behind it waits in its update cycle
// until the held result is taken.
// Reset (synchronous, rst_n low) empties every slot and sets capacity to 16.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lkv_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [lkv_pkg::KEY_W-1:0]        in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value
);
  import lkv_pkg::*;

  lkv_cmd_t  cmd;
  lkv_stat_t stat;

  // sequencing and handshake
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slots, compare and shift
  lkv_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

endmodule
